### rtl/sqlc_pkg.sv
// ----------------------------------------------------------------------------
// sqlc_pkg
// shared types, keyword rule table and helpers for the sql statement classifier
// ----------------------------------------------------------------------------
package sqlc_pkg;

    localparam int PREFIX_LEN = 21;
    localparam int CNT_W      = $clog2(PREFIX_LEN + 1);
    localparam int POS_W      = $clog2(PREFIX_LEN);
    localparam int RULE_COUNT = 40;
    localparam int KW_MAX     = 21;
    localparam int CLS_W      = 6;
    localparam int WIN_W      = 40;

    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 6'd0;
    localparam logic [CLS_W-1:0] CLS_INSERT  = 6'd15;
    localparam logic [CLS_W-1:0] CLS_SHOW    = 6'd28;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [47:0] WORD_SELECT = "SELECT";
    localparam logic [47:0] WORD_CREATE = "CREATE";

    // keywords are right-justified: first byte sits highest
    localparam logic [8*KW_MAX-1:0] RULE_KW [RULE_COUNT] = '{
        "ALTER TABLE", "ALTER USER", "ANALYZE TABLE", "CALL", "CHECKSUM", "COMMIT",
        "CREATE INDEX", "DROP INDEX", "CREATE DATABASE", "RENAME DATABASE",
        "DROP DATABASE", "CREATE TABLE", "DROP TABLE", "CREATE USER", "RENAME USER",
        "DROP USER", "CREATE VIEW", "DROP VIEW", "DELETE", "DO", "FLUSH", "GRANT",
        "INSERT", "INSTALL PLUGIN", "KILL", "LOAD INDEX INTO CACHE", "OPTIMIZE TABLE",
        "RENAME TABLE", "REPAIR TABLE", "REPLACE", "RESET", "REVOKE", "SELECT", "SET",
        "SHOW", "START REPLICA", "STOP REPLICA", "TRUNCATE", "UNINSTALL PLUGIN",
        "UPDATE"
    };

    localparam logic [7:0] RULE_LEN [RULE_COUNT] = '{
        8'd11, 8'd10, 8'd13, 8'd4, 8'd8, 8'd6,
        8'd12, 8'd10, 8'd15, 8'd15,
        8'd13, 8'd12, 8'd10, 8'd11, 8'd11,
        8'd9, 8'd11, 8'd9, 8'd6, 8'd2, 8'd5, 8'd5,
        8'd6, 8'd14, 8'd4, 8'd21, 8'd14,
        8'd12, 8'd12, 8'd7, 8'd5, 8'd6, 8'd6, 8'd3,
        8'd4, 8'd13, 8'd12, 8'd8, 8'd16,
        8'd6
    };

    localparam logic [CLS_W-1:0] RULE_CLS [RULE_COUNT] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6,
        6'd7, 6'd7, 6'd8, 6'd8,
        6'd8, 6'd9, 6'd9, 6'd10, 6'd10,
        6'd10, 6'd9, 6'd9, 6'd11, 6'd12, 6'd13, 6'd14,
        CLS_INSERT, 6'd17, 6'd18, 6'd19, 6'd20,
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
        CLS_SHOW, 6'd30, 6'd30, 6'd31, 6'd32,
        6'd33
    };

    // byte i of keyword k, zero past its end
    function automatic logic [7:0] kw_byte(int k, int i);
        int len;
        logic [7:0] b;
        len = int'(RULE_LEN[k]);
        b   = 8'h00;
        if (i < len)
        begin
            b = RULE_KW[k][8*(len-1-i) +: 8];
        end
        return b;
    endfunction

    // one normalized byte and the stream state after it
    typedef struct packed {
        logic [7:0]        data;
        logic              store;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  count_after;
        logic              saw_select_after;
        logic              saw_create_after;
    } sqlc_keep_t;

endpackage

### rtl/sqlc_norm.sv
// ----------------------------------------------------------------------------
// sqlc_norm
// quote dropping, space collapsing, upper-casing, kept count and keyword window
// ----------------------------------------------------------------------------
module sqlc_norm
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                last,
    input  logic [7:0]          data_in,
    output sqlc_pkg::sqlc_keep_t keep
);

    logic                        in_quotes_reg,   in_quotes_next;
    logic                        after_space_reg, after_space_next;
    logic [sqlc_pkg::CNT_W-1:0]  count_reg,       count_next;
    logic [sqlc_pkg::WIN_W-1:0]  recent_reg,      recent_next;
    logic                        saw_select_reg,  saw_select_next;
    logic                        saw_create_reg,  saw_create_next;

    logic                        kept;
    logic [7:0]                  upper;
    logic [47:0]                 win;
    logic                        store;

    always_comb
    begin
        in_quotes_next   = in_quotes_reg;
        after_space_next = after_space_reg;
        kept             = 1'b0;
        if (in_quotes_reg)
        begin
            if (data_in == sqlc_pkg::CH_QUOTE)
            begin
                in_quotes_next = 1'b0;
            end
        end
        else if (data_in == sqlc_pkg::CH_QUOTE)
        begin
            in_quotes_next = 1'b1;
        end
        else if (!(after_space_reg && data_in == sqlc_pkg::CH_SPACE))
        begin
            after_space_next = (data_in == sqlc_pkg::CH_SPACE);
            kept             = 1'b1;
        end

        upper = data_in;
        if (data_in >= sqlc_pkg::CH_LC_A && data_in <= sqlc_pkg::CH_LC_Z)
        begin
            upper = data_in - sqlc_pkg::CASE_OFS;
        end

        win   = {recent_reg, upper};
        store = kept && (count_reg < sqlc_pkg::CNT_W'(sqlc_pkg::PREFIX_LEN));

        recent_next     = recent_reg;
        saw_select_next = saw_select_reg;
        saw_create_next = saw_create_reg;
        count_next      = count_reg;
        if (kept)
        begin
            recent_next     = win[sqlc_pkg::WIN_W-1:0];
            saw_select_next = saw_select_reg || (win == sqlc_pkg::WORD_SELECT);
            saw_create_next = saw_create_reg || (win == sqlc_pkg::WORD_CREATE);
        end
        if (store)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign keep.data             = upper;
    assign keep.store            = store;
    assign keep.pos              = count_reg[sqlc_pkg::POS_W-1:0];
    assign keep.count_after      = count_next;
    assign keep.saw_select_after = saw_select_next;
    assign keep.saw_create_after = saw_create_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg   <= 1'b0;
            after_space_reg <= 1'b0;
            count_reg       <= '0;
            recent_reg      <= '0;
            saw_select_reg  <= 1'b0;
            saw_create_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                // statement done, start clean
                in_quotes_reg   <= 1'b0;
                after_space_reg <= 1'b0;
                count_reg       <= '0;
                recent_reg      <= '0;
                saw_select_reg  <= 1'b0;
                saw_create_reg  <= 1'b0;
            end
            else
            begin
                in_quotes_reg   <= in_quotes_next;
                after_space_reg <= after_space_next;
                count_reg       <= count_next;
                recent_reg      <= recent_next;
                saw_select_reg  <= saw_select_next;
                saw_create_reg  <= saw_create_next;
            end
        end
    end

endmodule

### rtl/sqlc_match.sv
// ----------------------------------------------------------------------------
// sqlc_match
// per-rule prefix match bits, updated one kept byte at a time, and the
// first-match class select
// ----------------------------------------------------------------------------
module sqlc_match
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      last,
    input  sqlc_pkg::sqlc_keep_t      keep,
    output logic [sqlc_pkg::CLS_W-1:0] class_code
);

    logic [sqlc_pkg::RULE_COUNT-1:0] match_reg, match_next;
    logic [sqlc_pkg::RULE_COUNT-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < sqlc_pkg::RULE_COUNT; k++)
        begin
            match_next[k] = match_reg[k];
            if (keep.store && (8'(keep.pos) < sqlc_pkg::RULE_LEN[k])
                && (keep.data != sqlc_pkg::kw_byte(k, int'(keep.pos))))
            begin
                match_next[k] = 1'b0;
            end
            hit[k] = match_next[k] && (8'(keep.count_after) >= sqlc_pkg::RULE_LEN[k]);
        end
    end

    // first rule that hits wins
    always_comb
    begin
        class_code = sqlc_pkg::CLS_UNKNOWN;
        for (int k = sqlc_pkg::RULE_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                class_code = sqlc_pkg::RULE_CLS[k];
                if (sqlc_pkg::RULE_CLS[k] == sqlc_pkg::CLS_INSERT && !keep.saw_select_after)
                begin
                    class_code = sqlc_pkg::CLS_INSERT + 1'b1;
                end
                if (sqlc_pkg::RULE_CLS[k] == sqlc_pkg::CLS_SHOW && !keep.saw_create_after)
                begin
                    class_code = sqlc_pkg::CLS_SHOW + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '1;
        end
        else if (step)
        begin
            if (last)
            begin
                match_reg <= '1;
            end
            else
            begin
                match_reg <= match_next;
            end
        end
    end

endmodule

### rtl/sql_statement_classifier_core.sv
// ----------------------------------------------------------------------------
// sql_statement_classifier_core
// streaming sql statement classifier, one character per transfer
// ----------------------------------------------------------------------------
// Characters enter through an input register and are processed one per clock
// unless held back: quoted text is dropped, repeated spaces collapse, letters
// are upper-cased, and each kept byte within the first PREFIX_LEN updates a
// match bit per keyword rule. One character is taken every cycle unless held
// back; a last character writes its class to the result register and clears
// the statement state for the next one. The path from the input register
// through the match update and the priority select to the result register
// sets the clock. A full result register holds back the input only when the
// character waiting in the input register is a last one.
// ----------------------------------------------------------------------------
module sql_statement_classifier_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [7:0]                  character,
    input  logic                        final_char,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [sqlc_pkg::CLS_W-1:0]  statement_class
);

    logic                        full_reg;
    logic [7:0]                  char_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic [sqlc_pkg::CLS_W-1:0]  class_reg;

    logic                        step;
    logic                        slot_free;
    sqlc_pkg::sqlc_keep_t        keep;
    logic [sqlc_pkg::CLS_W-1:0]  class_code;

    assign slot_free  = !out_valid_reg || result_ready;
    assign step       = full_reg && (!last_reg || slot_free);
    assign item_ready = !full_reg || step;

    sqlc_norm u_norm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .last    (last_reg),
        .data_in (char_reg),
        .keep    (keep)
    );

    sqlc_match u_match
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .last       (last_reg),
        .keep       (keep),
        .class_code (class_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            full_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            char_reg <= character;
            last_reg <= final_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
        begin
            class_reg <= class_code;
        end
    end

    assign result_valid    = out_valid_reg;
    assign statement_class = class_reg;

endmodule
